[hw/rtl/first_fit_block_allocator_defines.svh]
// Assertion macros shared by the checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the next cycle.
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the same cycle.
`define FFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/ffba_pkg.sv]
package ffba_pkg;

  localparam int unsigned ArenaBytesDef  = 1024;
  localparam int unsigned HeaderBytesDef = 16;
  localparam int unsigned MaxBlocksDef   = 64;

  localparam int unsigned HandleW = 10;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned StatusW = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [StatusW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatusW-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_HDL = 2'd2;

  // Operation broadcast from the controller to every cell.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MATCH,
    OP_SPLIT,
    OP_MARK,
    OP_MERGE
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SELECT,
    S_APPLY,
    S_MERGE2,
    S_DONE
  } state_e;

endpackage

[hw/rtl/ffba_cell.sv]
// One table entry. Cells shift toward higher indexes on a split and toward lower
// indexes on a merge; each cell also evaluates its own match flag.
module ffba_cell import ffba_pkg::*; #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned LenW  = 11,
  parameter int unsigned IdxW  = 6,
  parameter int unsigned Index = 0,
  parameter int unsigned ArenaBytes  = 1024,
  parameter int unsigned HeaderBytes = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_op_e        op,
  input  logic            cmd,
  input  logic [LenW:0]   need,
  input  logic [HandleW-1:0] handle,
  input  logic [IdxW-1:0] sel,
  input  logic [IdxW:0]   total,
  input  logic [LenW:0]   split_len,
  input  logic [AddrW-1:0] prev_start,
  input  logic [LenW-1:0] prev_len,
  input  logic            prev_free,
  input  logic [AddrW-1:0] next_start,
  input  logic [LenW-1:0] next_len,
  input  logic            next_free,
  output logic [AddrW-1:0] start_o,
  output logic [LenW-1:0] len_o,
  output logic            free_o,
  output logic            hit_o
);

  logic [AddrW-1:0] start_r, start_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic             free_r, free_nxt;
  logic             hit_r, hit_nxt;
  logic [IdxW:0]    me;
  logic             used;
  logic [AddrW+6:0] pay;

  assign me   = (IdxW+1)'(Index);
  assign used = me < total;
  assign pay  = (AddrW+7)'(start_r) + (AddrW+7)'(HeaderBytes);

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    free_nxt  = free_r;
    hit_nxt   = hit_r;
    unique case (op)
      OP_HOLD: ;
      OP_MATCH: begin
        if (cmd == CMD_ALLOC) begin
          hit_nxt = used && free_r && ({1'b0, len_r} >= need);
        end else begin
          hit_nxt = used && !free_r && (pay == (AddrW+7)'(handle));
        end
      end
      OP_SPLIT: begin
        // Split the selected entry; split_len is nonzero only when a remainder is made.
        if (me == {1'b0, sel}) begin
          if (split_len != '0) len_nxt = LenW'(need);
          free_nxt = 1'b0;
        end else if (split_len != '0 && me == {1'b0, sel} + 1'b1) begin
          start_nxt = AddrW'((AddrW+1)'(prev_start) + (AddrW+1)'(need));
          len_nxt   = LenW'(split_len);
          free_nxt  = 1'b1;
        end else if (split_len != '0 && me > {1'b0, sel} + 1'b1 && me <= total) begin
          start_nxt = prev_start;
          len_nxt   = prev_len;
          free_nxt  = prev_free;
        end
      end
      OP_MARK: begin
        if (me == {1'b0, sel}) free_nxt = 1'b1;
      end
      OP_MERGE: begin
        // Fold entry sel+1 into sel and close the gap.
        if (me == {1'b0, sel}) begin
          len_nxt = len_r + next_len;
        end else if (me > {1'b0, sel} && me + 1'b1 < total) begin
          start_nxt = next_start;
          len_nxt   = next_len;
          free_nxt  = next_free;
        end else if (me > {1'b0, sel} && me + 1'b1 == total) begin
          start_nxt = '0;
          len_nxt   = '0;
          free_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= (Index == 0) ? LenW'(ArenaBytes) : '0;
      free_r  <= (Index == 0);
      hit_r   <= 1'b0;
    end else begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
      free_r  <= free_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign start_o = start_r;
  assign len_o   = len_r;
  assign free_o  = free_r;
  assign hit_o   = hit_r;

endmodule

[hw/rtl/ffba_prio.sv]
// Lowest set hit flag, found through a registered tree of small groups.
module ffba_prio import ffba_pkg::*; #(
  parameter int unsigned N    = 64,
  parameter int unsigned IdxW = 6
) (
  input  logic            clk,
  input  logic [N-1:0]    hits,
  output logic            found_o,
  output logic [IdxW-1:0] idx_o
);

  localparam int unsigned G  = 8;
  localparam int unsigned NG = (N + G - 1) / G;

  logic [NG-1:0]   gany_r;
  logic [IdxW-1:0] gidx_r [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_ff @(posedge clk) begin
      logic [IdxW-1:0] x;
      logic            a;
      x = '0;
      a = 1'b0;
      for (int b = G - 1; b >= 0; b--) begin
        if (g * G + b < N) begin
          if (hits[g * G + b]) begin
            a = 1'b1;
            x = IdxW'(g * G + b);
          end
        end
      end
      gany_r[g] <= a;
      gidx_r[g] <= x;
    end
  end

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (gany_r[g]) begin
        found_o = 1'b1;
        idx_o   = gidx_r[g];
      end
    end
  end

endmodule

[hw/rtl/first_fit_block_allocator.sv]
// Channel   Ports                                       Handshake
// in        in_command, in_request_size, in_release_handle   start & !busy
// out       out_status, out_granted_handle              out_valid, one-cycle strobe
// After the accepting edge: match, priority tree, select; a failed request then goes to
// the result, an allocate applies the split and a free goes through marking and merging.
// Busy stays high through the result beat, so the next request is accepted only after it.
// Reset is synchronous; the table holds one free block covering the arena.
// Results cannot stall.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned ARENA_BYTES  = ArenaBytesDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef,
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [SizeW-1:0]   in_request_size,
  input  logic [HandleW-1:0] in_release_handle,
  output logic               out_valid,
  output logic [StatusW-1:0] out_status,
  output logic [HandleW-1:0] out_granted_handle
);

  localparam int unsigned AddrW = $clog2(ARENA_BYTES);
  localparam int unsigned LenW  = $clog2(ARENA_BYTES + 1);
  localparam int unsigned IdxW  = $clog2(MAX_BLOCKS);
  localparam int unsigned NeedW = (LenW > SizeW ? LenW : SizeW) + 1;

  state_e state_r, state_nxt;
  logic   cmd_r;
  logic [NeedW-1:0]   need_r;
  logic [HandleW-1:0] hdl_r;
  logic [IdxW:0]      total_r, total_nxt;
  logic [IdxW-1:0]    sel_r, sel_nxt;
  logic               merge2_r, merge2_nxt;
  logic [StatusW-1:0] st_r, st_nxt;
  logic [HandleW-1:0] gh_r, gh_nxt;
  cell_op_e           op;
  logic [LenW:0]      split_len;

  logic [AddrW-1:0] st_a [MAX_BLOCKS];
  logic [LenW-1:0]  ln_a [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] fr_a, hit_a;
  logic             found;
  logic [IdxW-1:0]  fidx;
  logic [LenW:0]    need_c;
  logic [LenW:0]    rest;
  logic [AddrW+6:0] gpay;

  // Requests larger than the arena cannot fit; clamp so the compare stays narrow.
  assign need_c = (need_r > NeedW'(ARENA_BYTES)) ? (LenW+1)'(ARENA_BYTES + 1)
                                                 : (LenW+1)'(need_r);

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffba_cell #(
      .AddrW(AddrW), .LenW(LenW), .IdxW(IdxW), .Index(i),
      .ArenaBytes(ARENA_BYTES), .HeaderBytes(HEADER_BYTES)
    ) u_cell (
      .clk, .rst_n, .op, .cmd(cmd_r), .need(need_c), .handle(hdl_r),
      .sel(sel_r), .total(total_r), .split_len,
      .prev_start(st_a[(i == 0) ? 0 : i - 1]),
      .prev_len  (ln_a[(i == 0) ? 0 : i - 1]),
      .prev_free (fr_a[(i == 0) ? 0 : i - 1]),
      .next_start(st_a[(i == MAX_BLOCKS - 1) ? i : i + 1]),
      .next_len  (ln_a[(i == MAX_BLOCKS - 1) ? i : i + 1]),
      .next_free (fr_a[(i == MAX_BLOCKS - 1) ? i : i + 1]),
      .start_o(st_a[i]), .len_o(ln_a[i]), .free_o(fr_a[i]), .hit_o(hit_a[i])
    );
  end

  ffba_prio #(.N(MAX_BLOCKS), .IdxW(IdxW)) u_prio (
    .clk, .hits(hit_a), .found_o(found), .idx_o(fidx)
  );

  assign rest = {1'b0, ln_a[sel_r]} - need_c;
  assign gpay = (AddrW+7)'(st_a[sel_r]) + (AddrW+7)'(HEADER_BYTES);

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    sel_nxt    = sel_r;
    merge2_nxt = merge2_r;
    st_nxt     = st_r;
    gh_nxt     = gh_r;
    op         = OP_HOLD;
    split_len  = '0;
    unique case (state_r)
      S_IDLE: if (start && !busy) state_nxt = S_MATCH;
      S_MATCH: begin
        op = OP_MATCH;
        state_nxt = S_SELECT;
      end
      S_SELECT: state_nxt = S_APPLY;
      S_APPLY: begin
        sel_nxt = fidx;
        gh_nxt  = '0;
        if (!found) begin
          st_nxt    = (cmd_r == CMD_ALLOC) ? ST_NO_FIT : ST_BAD_HDL;
          state_nxt = S_DONE;
        end else begin
          st_nxt    = ST_DONE;
          state_nxt = S_MERGE2;
        end
      end
      S_MERGE2: begin
        // First pass applies the split or marks free; merge2_r tracks the merge sequence.
        if (cmd_r == CMD_ALLOC) begin
          op = OP_SPLIT;
          if (rest >= (LenW+1)'(HEADER_BYTES) && total_r < (IdxW+1)'(MAX_BLOCKS)) begin
            split_len = rest;
            total_nxt = total_r + 1'b1;
          end
          gh_nxt    = HandleW'(gpay);
          state_nxt = S_DONE;
        end else if (!merge2_r) begin
          op = OP_MARK;
          merge2_nxt = 1'b1;
        end else begin
          merge2_nxt = 1'b0;
          state_nxt  = S_DONE;
          if ({1'b0, sel_r} + 1'b1 < total_r && fr_a[sel_r + 1'b1]) begin
            op = OP_MERGE;
            total_nxt = total_r - 1'b1;
            merge2_nxt = 1'b1;
            state_nxt  = S_MERGE2;
            if (sel_r != '0 && fr_a[sel_r - 1'b1]) begin
              sel_nxt = sel_r - 1'b1;
            end else begin
              merge2_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
          end else if (sel_r != '0 && fr_a[sel_r - 1'b1]) begin
            // Step back to the predecessor; the next cycle folds this entry into it.
            sel_nxt    = sel_r - 1'b1;
            merge2_nxt = 1'b1;
            state_nxt  = S_MERGE2;
          end
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // The merge into the predecessor uses the decremented sel in the following cycle.
  logic pend_r, pend_nxt;
  always_comb begin
    pend_nxt = 1'b0;
    if (state_r == S_MERGE2 && cmd_r == CMD_FREE && merge2_r && state_nxt == S_MERGE2)
      pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= (IdxW+1)'(1);
      merge2_r <= 1'b0;
      pend_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r  <= (pend_r) ? S_DONE : state_nxt;
      total_r  <= (pend_r) ? total_r - 1'b1 : total_nxt;
      merge2_r <= (pend_r) ? 1'b0 : merge2_nxt;
      pend_r   <= pend_nxt;
      out_valid <= (state_r == S_DONE) && !pend_r;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    st_r  <= st_nxt;
    gh_r  <= gh_nxt;
    if (state_r == S_IDLE && start && !busy) begin
      cmd_r  <= in_command;
      need_r <= NeedW'(in_request_size) + NeedW'(HEADER_BYTES);
      hdl_r  <= in_release_handle;
    end
    if (state_r == S_DONE) begin
      out_status         <= st_r;
      out_granted_handle <= gh_r;
    end
  end

  assign busy = (state_r != S_IDLE) || out_valid;

endmodule

[hw/rtl/ffba_checker.sv]
`include "first_fit_block_allocator_defines.svh"
module ffba_checker import ffba_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [StatusW-1:0] out_status,
  input logic [HandleW-1:0] out_granted_handle
);

  `FFA_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  `FFA_ASSERT_NOW(a_status_range, clk, rst_n, out_valid, out_status != 2'd3)
  `FFA_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_status != ST_DONE,
    out_granted_handle == '0)
  `FFA_ASSERT_NEXT(a_single_beat, clk, rst_n, out_valid, !out_valid)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_granted_handle
);
